@@ rtl/core/rgb_kernel_convolution_clamp_macros.svh @@
// ----------------------------------------------------------------------------
// rgb kernel convolution clamp assertion macros
// shared concurrent assertion forms, clocked on clk, disabled in reset
// ----------------------------------------------------------------------------
`ifndef RGB_KERNEL_CONVOLUTION_CLAMP_MACROS_SVH
`define RGB_KERNEL_CONVOLUTION_CLAMP_MACROS_SVH

// same-cycle implication
`define RKC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RKC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/core/rkc_pkg.sv @@
// ----------------------------------------------------------------------------
// rkc_pkg
// shared constants, types and codes of the rgb kernel convolution block
// ----------------------------------------------------------------------------
package rkc_pkg;

  localparam int MAX_WIDTH   = 1024;
  localparam int COL_W       = $clog2(MAX_WIDTH);
  localparam int KERNEL_SIZE = 3;
  localparam int COEFF_BITS  = 16;
  localparam int SLOT_W      = 16;
  localparam int NPLANE      = 3;
  localparam int SAMPLE_W    = 8;
  localparam int PIX_W       = NPLANE * SAMPLE_W;
  localparam int PROD_W      = SAMPLE_W + 1 + SLOT_W;
  localparam int ACC_W       = 28;
  localparam int MAG_W       = ACC_W - 1;
  localparam int DIV_W       = 16;
  localparam int CNT_W       = $clog2(MAG_W);
  localparam int ROW_W       = 16;
  localparam int WID_W       = 11;
  localparam int KROW_W      = 48;
  localparam int STEP_W      = 4;
  localparam int SAMPLE_MAX  = 255;

  localparam logic [2:0] REG_KTOP   = 3'd0;
  localparam logic [2:0] REG_KMID   = 3'd1;
  localparam logic [2:0] REG_KBOT   = 3'd2;
  localparam logic [2:0] REG_DIV    = 3'd3;
  localparam logic [2:0] REG_WIDTH  = 3'd4;
  localparam logic [2:0] REG_HEIGHT = 3'd5;

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [MAG_W-1:0] mag_t;
  typedef logic [SAMPLE_W-1:0] sample_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_DSTART,
    ST_DWAIT,
    ST_DONE
  } state_t;

endpackage

@@ rtl/core/rgb_kernel_convolution_clamp.sv @@
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_clamp
// 3x3 rgb convolution with divisor and clamp over a raster pixel stream
// ----------------------------------------------------------------------------
// After reset the line ram is cleared, during which no pixel request is
// taken; configuration writes are taken at any time. Each pixel then takes
// a ram read in the idle state and a write-back in the load state. Border
// pixels end there. An interior pixel also runs a multiply-accumulate over
// the nine taps on one multiplier per colour plane, a divider start state,
// then a restoring divider of 27 steps and a done state, which also waits
// for the output register. The next pixel is taken while a result still
// waits at the output register.
module rgb_kernel_convolution_clamp (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_frame_last,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  `include "rgb_kernel_convolution_clamp_macros.svh"

  rkc_pkg::state_t state_r, state_nxt;

  logic [rkc_pkg::COL_W-1:0]  clr_r, clr_nxt;
  logic [rkc_pkg::COL_W-1:0]  col_r, col_nxt;
  logic [rkc_pkg::ROW_W-1:0]  row_r, row_nxt;
  logic [rkc_pkg::STEP_W-1:0] st_r, st_nxt;
  logic [1:0]                 mi_r, mi_nxt, mj_r, mj_nxt;
  logic                       fl_r, fl_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic                       out_load;

  rkc_pkg::pix_t cur_r;
  rkc_pkg::pix_t win_r [rkc_pkg::KERNEL_SIZE][rkc_pkg::KERNEL_SIZE];
  logic signed [rkc_pkg::PROD_W-1:0] prod_r [rkc_pkg::NPLANE];
  logic signed [rkc_pkg::PROD_W-1:0] prod_nxt [rkc_pkg::NPLANE];
  logic signed [rkc_pkg::ACC_W-1:0]  acc_r [rkc_pkg::NPLANE];
  logic signed [rkc_pkg::ACC_W-1:0]  acc_nxt [rkc_pkg::NPLANE];
  rkc_pkg::sample_t out_r [rkc_pkg::NPLANE];
  logic             out_fl_r;

  logic [rkc_pkg::KROW_W-1:0] ktop_r, kmid_r, kbot_r;
  logic [rkc_pkg::DIV_W-1:0]  div_r;
  logic [rkc_pkg::WID_W-1:0]  wid_r;
  logic [rkc_pkg::ROW_W-1:0]  hgt_r;
  logic                       cfg_we;
  logic [2:0]                 cfg_idx;

  logic                        ram_we;
  logic [rkc_pkg::COL_W-1:0]   ram_waddr;
  logic [2*rkc_pkg::PIX_W-1:0] ram_wdata, ram_rdata;
  rkc_pkg::pix_t               top_pix, mid_pix;

  logic [rkc_pkg::WID_W-1:0]  w_eff;
  logic [rkc_pkg::ROW_W:0]    h_eff;
  logic [rkc_pkg::DIV_W-1:0]  d_eff;
  logic                       row_end, frame_end, emit;

  logic [rkc_pkg::KROW_W-1:0]        krow;
  logic [rkc_pkg::SLOT_W-1:0]        slot;
  logic signed [rkc_pkg::SLOT_W-1:0] coef;
  rkc_pkg::pix_t                     mpix;

  logic             div_start, div_done;
  rkc_pkg::mag_t    dvd [rkc_pkg::NPLANE];
  rkc_pkg::sample_t quot [rkc_pkg::NPLANE];

  // configuration port
  assign pready  = 1'b1;
  assign cfg_idx = paddr[5:3];
  assign cfg_we  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ktop_r <= '0;
      kmid_r <= rkc_pkg::KROW_W'(65536);
      kbot_r <= '0;
      div_r  <= rkc_pkg::DIV_W'(1);
      wid_r  <= rkc_pkg::WID_W'(1024);
      hgt_r  <= rkc_pkg::ROW_W'(1024);
    end else if (cfg_we) begin
      unique case (cfg_idx)
        rkc_pkg::REG_KTOP:   ktop_r <= pwdata[rkc_pkg::KROW_W-1:0];
        rkc_pkg::REG_KMID:   kmid_r <= pwdata[rkc_pkg::KROW_W-1:0];
        rkc_pkg::REG_KBOT:   kbot_r <= pwdata[rkc_pkg::KROW_W-1:0];
        rkc_pkg::REG_DIV:    div_r  <= pwdata[rkc_pkg::DIV_W-1:0];
        rkc_pkg::REG_WIDTH:  wid_r  <= pwdata[rkc_pkg::WID_W-1:0];
        rkc_pkg::REG_HEIGHT: hgt_r  <= pwdata[rkc_pkg::ROW_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      rkc_pkg::REG_KTOP:   prdata = 64'(ktop_r);
      rkc_pkg::REG_KMID:   prdata = 64'(kmid_r);
      rkc_pkg::REG_KBOT:   prdata = 64'(kbot_r);
      rkc_pkg::REG_DIV:    prdata = 64'(div_r);
      rkc_pkg::REG_WIDTH:  prdata = 64'(wid_r);
      rkc_pkg::REG_HEIGHT: prdata = 64'(hgt_r);
      default:             prdata = '0;
    endcase
  end

  // effective geometry and divisor
  always_comb begin
    if (wid_r < rkc_pkg::WID_W'(3)) begin
      w_eff = rkc_pkg::WID_W'(3);
    end else if (wid_r > rkc_pkg::WID_W'(rkc_pkg::MAX_WIDTH)) begin
      w_eff = rkc_pkg::WID_W'(rkc_pkg::MAX_WIDTH);
    end else begin
      w_eff = wid_r;
    end
    h_eff = (hgt_r < rkc_pkg::ROW_W'(3)) ? (rkc_pkg::ROW_W+1)'(3) : {1'b0, hgt_r};
    d_eff = (div_r == '0) ? rkc_pkg::DIV_W'(1) : div_r;
  end

  // line ram: upper half older row, lower half newer row
  rkc_ram #(
    .WIDTH (2*rkc_pkg::PIX_W),
    .DEPTH (rkc_pkg::MAX_WIDTH)
  ) u_line_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr   (col_r),
    .rdata_r (ram_rdata)
  );

  assign top_pix = ram_rdata[2*rkc_pkg::PIX_W-1:rkc_pkg::PIX_W];
  assign mid_pix = ram_rdata[rkc_pkg::PIX_W-1:0];

  assign row_end   = ({1'b0, col_r} + 1'b1) >= w_eff;
  assign frame_end = row_end && (({1'b0, row_r} + 1'b1) >= h_eff);
  assign emit      = (row_r >= rkc_pkg::ROW_W'(2)) && (col_r >= rkc_pkg::COL_W'(2));

  // coefficient and pixel select for the current tap
  always_comb begin
    unique case (mi_r)
      2'd0:    krow = ktop_r;
      2'd1:    krow = kmid_r;
      default: krow = kbot_r;
    endcase
    unique case (mj_r)
      2'd0:    slot = krow[rkc_pkg::SLOT_W-1:0];
      2'd1:    slot = krow[2*rkc_pkg::SLOT_W-1:rkc_pkg::SLOT_W];
      default: slot = krow[3*rkc_pkg::SLOT_W-1:2*rkc_pkg::SLOT_W];
    endcase
    coef = rkc_pkg::SLOT_W'($signed(slot[rkc_pkg::COEFF_BITS-1:0]));
    mpix = win_r[mi_r][mj_r];
    for (int p = 0; p < rkc_pkg::NPLANE; p++) begin
      prod_nxt[p] = $signed({1'b0, mpix[p*rkc_pkg::SAMPLE_W +: rkc_pkg::SAMPLE_W]}) * coef;
      dvd[p]      = acc_r[p][rkc_pkg::ACC_W-1] ? '0 : acc_r[p][rkc_pkg::MAG_W-1:0];
    end
  end

  rkc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .dvd_i (dvd),
    .dsr_i (d_eff),
    .done  (div_done),
    .quot  (quot)
  );

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    col_nxt       = col_r;
    row_nxt       = row_r;
    st_nxt        = st_r;
    mi_nxt        = mi_r;
    mj_nxt        = mj_r;
    fl_nxt        = fl_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_load      = 1'b0;
    in_ready      = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = col_r;
    ram_wdata     = {mid_pix, cur_r};
    div_start     = 1'b0;
    for (int p = 0; p < rkc_pkg::NPLANE; p++) begin
      acc_nxt[p] = acc_r[p];
    end
    unique case (state_r)
      rkc_pkg::ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == rkc_pkg::COL_W'(rkc_pkg::MAX_WIDTH - 1)) begin
          state_nxt = rkc_pkg::ST_IDLE;
        end
      end
      rkc_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          state_nxt = rkc_pkg::ST_LOAD;
        end
      end
      rkc_pkg::ST_LOAD: begin
        ram_we = 1'b1;
        fl_nxt = frame_end;
        if (row_end) begin
          col_nxt = '0;
          row_nxt = frame_end ? '0 : row_r + 1'b1;
        end else begin
          col_nxt = col_r + 1'b1;
        end
        if (emit) begin
          state_nxt = rkc_pkg::ST_MAC;
          st_nxt    = '0;
          mi_nxt    = '0;
          mj_nxt    = '0;
          for (int p = 0; p < rkc_pkg::NPLANE; p++) begin
            acc_nxt[p] = '0;
          end
        end else begin
          state_nxt = rkc_pkg::ST_IDLE;
        end
      end
      rkc_pkg::ST_MAC: begin
        st_nxt = st_r + 1'b1;
        if (mj_r == 2'd2) begin
          mj_nxt = '0;
          mi_nxt = (mi_r == 2'd2) ? 2'd0 : mi_r + 1'b1;
        end else begin
          mj_nxt = mj_r + 1'b1;
        end
        if (st_r != '0) begin
          for (int p = 0; p < rkc_pkg::NPLANE; p++) begin
            acc_nxt[p] = acc_r[p] + rkc_pkg::ACC_W'(prod_r[p]);
          end
        end
        if (st_r == rkc_pkg::STEP_W'(rkc_pkg::KERNEL_SIZE * rkc_pkg::KERNEL_SIZE)) begin
          state_nxt = rkc_pkg::ST_DSTART;
        end
      end
      rkc_pkg::ST_DSTART: begin
        div_start = 1'b1;
        state_nxt = rkc_pkg::ST_DWAIT;
      end
      rkc_pkg::ST_DWAIT: begin
        if (div_done) begin
          state_nxt = rkc_pkg::ST_DONE;
        end
      end
      rkc_pkg::ST_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_load      = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = rkc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rkc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rkc_pkg::ST_CLEAR;
      clr_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      st_r        <= '0;
      mi_r        <= '0;
      mj_r        <= '0;
      fl_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      col_r       <= col_nxt;
      row_r       <= row_nxt;
      st_r        <= st_nxt;
      mi_r        <= mi_nxt;
      mj_r        <= mj_nxt;
      fl_r        <= fl_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      cur_r <= {in_blue_in, in_green_in, in_red_in};
    end
    if (state_r == rkc_pkg::ST_LOAD) begin
      for (int i = 0; i < rkc_pkg::KERNEL_SIZE; i++) begin
        win_r[i][0] <= win_r[i][1];
        win_r[i][1] <= win_r[i][2];
      end
      win_r[0][2] <= top_pix;
      win_r[1][2] <= mid_pix;
      win_r[2][2] <= cur_r;
    end
    for (int p = 0; p < rkc_pkg::NPLANE; p++) begin
      prod_r[p] <= prod_nxt[p];
      acc_r[p]  <= acc_nxt[p];
    end
    if (out_load) begin
      for (int p = 0; p < rkc_pkg::NPLANE; p++) begin
        out_r[p] <= quot[p];
      end
      out_fl_r <= fl_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_red_out    = out_r[0];
  assign out_green_out  = out_r[1];
  assign out_blue_out   = out_r[2];
  assign out_frame_last = out_fl_r;

  `RKC_ASSERT_NEXT(a_accept_loads, in_valid && in_ready, state_r == rkc_pkg::ST_LOAD, "request not loaded")
  `RKC_ASSERT_NOW(a_done_in_wait, div_done, state_r == rkc_pkg::ST_DWAIT, "divider done out of sequence")
  `RKC_ASSERT_NEXT(a_result_shown, out_load, out_valid_r, "result not presented")
  `RKC_ASSERT_NOW(a_no_write_idle, state_r == rkc_pkg::ST_IDLE, !ram_we, "line ram written while idle")

endmodule

@@ rtl/core/rkc_ram.sv @@
// ----------------------------------------------------------------------------
// rkc_ram
// generic single write, single read ram with registered read data
// ----------------------------------------------------------------------------
module rkc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

endmodule

@@ rtl/core/rkc_div.sv @@
// ----------------------------------------------------------------------------
// rkc_div
// three-lane restoring divider, one quotient bit per cycle, clamped to 255
// ----------------------------------------------------------------------------
module rkc_div (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      start,
  input  rkc_pkg::mag_t             dvd_i [rkc_pkg::NPLANE],
  input  logic [rkc_pkg::DIV_W-1:0] dsr_i,
  output logic                      done,
  output rkc_pkg::sample_t          quot [rkc_pkg::NPLANE]
);

  logic                      busy_r, busy_nxt;
  logic                      done_r, done_nxt;
  logic [rkc_pkg::CNT_W-1:0] cnt_r, cnt_nxt;
  logic [rkc_pkg::DIV_W-1:0] dsr_r, dsr_nxt;
  rkc_pkg::mag_t             dvd_r [rkc_pkg::NPLANE];
  rkc_pkg::mag_t             dvd_nxt [rkc_pkg::NPLANE];
  rkc_pkg::mag_t             q_r [rkc_pkg::NPLANE];
  rkc_pkg::mag_t             q_nxt [rkc_pkg::NPLANE];
  logic [rkc_pkg::DIV_W-1:0] rem_r [rkc_pkg::NPLANE];
  logic [rkc_pkg::DIV_W-1:0] rem_nxt [rkc_pkg::NPLANE];
  logic [rkc_pkg::DIV_W:0]   trial [rkc_pkg::NPLANE];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dsr_nxt  = dsr_r;
    for (int p = 0; p < rkc_pkg::NPLANE; p++) begin
      trial[p]   = {rem_r[p], dvd_r[p][rkc_pkg::MAG_W-1]};
      dvd_nxt[p] = dvd_r[p];
      q_nxt[p]   = q_r[p];
      rem_nxt[p] = rem_r[p];
    end
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      dsr_nxt  = dsr_i;
      for (int p = 0; p < rkc_pkg::NPLANE; p++) begin
        dvd_nxt[p] = dvd_i[p];
        q_nxt[p]   = '0;
        rem_nxt[p] = '0;
      end
    end else if (busy_r) begin
      for (int p = 0; p < rkc_pkg::NPLANE; p++) begin
        dvd_nxt[p] = {dvd_r[p][rkc_pkg::MAG_W-2:0], 1'b0};
        if (trial[p] >= {1'b0, dsr_r}) begin
          rem_nxt[p] = rkc_pkg::DIV_W'(trial[p] - {1'b0, dsr_r});
          q_nxt[p]   = {q_r[p][rkc_pkg::MAG_W-2:0], 1'b1};
        end else begin
          rem_nxt[p] = trial[p][rkc_pkg::DIV_W-1:0];
          q_nxt[p]   = {q_r[p][rkc_pkg::MAG_W-2:0], 1'b0};
        end
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == rkc_pkg::CNT_W'(rkc_pkg::MAG_W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dsr_r <= dsr_nxt;
    for (int p = 0; p < rkc_pkg::NPLANE; p++) begin
      dvd_r[p] <= dvd_nxt[p];
      q_r[p]   <= q_nxt[p];
      rem_r[p] <= rem_nxt[p];
    end
  end

  assign done = done_r;

  always_comb begin
    for (int p = 0; p < rkc_pkg::NPLANE; p++) begin
      quot[p] = (|q_r[p][rkc_pkg::MAG_W-1:rkc_pkg::SAMPLE_W])
              ? rkc_pkg::SAMPLE_W'(rkc_pkg::SAMPLE_MAX) : q_r[p][rkc_pkg::SAMPLE_W-1:0];
    end
  end

endmodule

@@ tb/sv/testbench.sv @@
// ----------------------------------------------------------------------------
// rgb_kernel_convolution_clamp testbench
// streams rgb pixels through the 3x3 convolution under several kernels,
// divisors and image geometries, predicts every filtered pixel in a
// scoreboard and checks each result in order, with random idling on both
// sides, a long output hold-off and register writes between phases
// ----------------------------------------------------------------------------
module testbench;

  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  in_red_in = '0, in_green_in = '0, in_blue_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  out_red_out, out_green_out, out_blue_out;
  logic        out_frame_last;
  logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [5:0]  paddr = '0;
  logic [63:0] pwdata = '0;
  logic [63:0] prdata;
  logic        pready;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int hold_req = 0;

  always #2 clk = ~clk;

  rgb_kernel_convolution_clamp i_dut (.*);

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       last;
  } filtered_pixel_t;

  class conv_scoreboard;
    logic [47:0] kernel_rows[3];
    logic [15:0] divisor;
    logic [10:0] width;
    logic [15:0] height;
    logic [23:0] line_mem[2][rkc_pkg::MAX_WIDTH];
    logic [23:0] window[3][3];
    int unsigned col_cnt, row_cnt;
    filtered_pixel_t expected_q[$];
    int errors;

    function new();
      kernel_rows[0] = '0;
      kernel_rows[1] = 48'h10000;
      kernel_rows[2] = '0;
      divisor = 16'd1;
      width = 11'd1024;
      height = 16'd1024;
      foreach (line_mem[i, j]) line_mem[i][j] = '0;
      foreach (window[i, j]) window[i][j] = '0;
      col_cnt = 0;
      row_cnt = 0;
      errors = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [63:0] v);
      case (idx)
        rkc_pkg::REG_KTOP:   kernel_rows[0] = v[47:0];
        rkc_pkg::REG_KMID:   kernel_rows[1] = v[47:0];
        rkc_pkg::REG_KBOT:   kernel_rows[2] = v[47:0];
        rkc_pkg::REG_DIV:    divisor = v[15:0];
        rkc_pkg::REG_WIDTH:  width = v[10:0];
        rkc_pkg::REG_HEIGHT: height = v[15:0];
        default: ;
      endcase
    endfunction

    function logic [7:0] plane_value(int shift, longint dv);
      longint acc;
      shortint coeff;
      acc = 0;
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++) begin
          coeff = kernel_rows[i][16*j +: 16];
          acc += longint'((window[i][j] >> shift) & 24'hff) * longint'(coeff);
        end
      acc = acc / dv;
      if (acc < 0) acc = 0;
      if (acc > 255) acc = 255;
      return acc[7:0];
    endfunction

    function void note_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
      int unsigned w, h, col, row;
      longint dv;
      logic [23:0] cur, top, mid;
      logic row_end, frame_end;
      filtered_pixel_t res;
      w = width < 3 ? 3 : (width > rkc_pkg::MAX_WIDTH ? rkc_pkg::MAX_WIDTH : width);
      h = height < 3 ? 3 : height;
      dv = divisor == 0 ? 1 : divisor;
      cur = {b, g, r};
      col = col_cnt < rkc_pkg::MAX_WIDTH ? col_cnt : rkc_pkg::MAX_WIDTH - 1;
      row = row_cnt;
      top = line_mem[1][col];
      mid = line_mem[0][col];
      line_mem[1][col] = mid;
      line_mem[0][col] = cur;
      for (int i = 0; i < 3; i++) begin
        window[i][0] = window[i][1];
        window[i][1] = window[i][2];
      end
      window[0][2] = top;
      window[1][2] = mid;
      window[2][2] = cur;
      row_end = col + 1 >= w;
      frame_end = row_end && row + 1 >= h;
      if (row >= 2 && col >= 2) begin
        res.red = plane_value(0, dv);
        res.green = plane_value(8, dv);
        res.blue = plane_value(16, dv);
        res.last = frame_end;
        expected_q.push_back(res);
      end
      if (row_end) begin
        col_cnt = 0;
        row_cnt = frame_end ? 0 : ((row + 1) & 16'hffff);
      end else begin
        col_cnt = col + 1;
      end
    endfunction

    function void check_result(filtered_pixel_t got);
      filtered_pixel_t exp_px;
      if (expected_q.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result r=%0d g=%0d b=%0d last=%0d",
                   got.red, got.green, got.blue, got.last);
        return;
      end
      exp_px = expected_q.pop_front();
      if (got !== exp_px) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: expected r=%0d g=%0d b=%0d last=%0d, got r=%0d g=%0d b=%0d last=%0d",
                   exp_px.red, exp_px.green, exp_px.blue, exp_px.last,
                   got.red, got.green, got.blue, got.last);
      end
    endfunction
  endclass

  conv_scoreboard sb = new();

  // result side: random stalls plus a counted hold-off
  int hold_left = 0;
  always @(posedge clk) begin
    filtered_pixel_t got;
    if (rst_n && out_valid && out_ready) begin
      got.red = out_red_out;
      got.green = out_green_out;
      got.blue = out_blue_out;
      got.last = out_frame_last;
      sb.check_result(got);
    end
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [63:0] v);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 3'b000};
    pwdata <= v;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    sb.write_reg(idx, v);
    @(posedge clk);
  endtask

  task automatic send_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_red_in <= r;
    in_green_in <= g;
    in_blue_in <= b;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(r, g, b);
  endtask

  task automatic send_random_pixel();
    send_pixel($urandom, $urandom, $urandom);
  endtask

  // pause the request stream until every expected result has come
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  function automatic logic [15:0] random_coeff(bit wide);
    if (wide) return 16'($urandom);
    return 16'($urandom_range(8)) - 16'd4;
  endfunction

  task automatic random_setup();
    bit wide;
    wide = ($urandom_range(3) == 0);
    for (int k = 0; k < 3; k++)
      write_reg(rkc_pkg::REG_KTOP + k[2:0], {16'($urandom), random_coeff(wide),
                                            random_coeff(wide), random_coeff(wide)});
    write_reg(rkc_pkg::REG_DIV, {48'($urandom), wide ? 16'($urandom_range(1, 65535))
                                                   : 16'($urandom_range(1, 16))});
    write_reg(rkc_pkg::REG_WIDTH, 64'($urandom_range(3, 8)));
    write_reg(rkc_pkg::REG_HEIGHT, 64'($urandom_range(3, 6)));
  endtask

  initial begin
    #4000000;
    $display("Some tests failed");
    $finish;
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // degenerate geometry and zero divisor, identity kernel
    write_reg(rkc_pkg::REG_WIDTH, 64'd0);
    write_reg(rkc_pkg::REG_HEIGHT, 64'd1);
    write_reg(rkc_pkg::REG_DIV, 64'd0);
    write_reg(REG_SPARE_LO, 64'hffff_ffff_ffff_ffff);
    write_reg(REG_SPARE_HI, 64'd5);
    for (int k = 0; k < 9; k++)
      send_pixel(k[0] ? 8'hff : 8'h00, k[1] ? 8'hff : 8'h00, 8'h80 | k[7:0]);
    drain();

    // extreme coefficients, largest divisor and none
    write_reg(rkc_pkg::REG_KTOP, {16'hffff, 16'h8000, 16'h8000, 16'h8000});
    write_reg(rkc_pkg::REG_KMID, 64'h0000_7fff_7fff_7fff);
    write_reg(rkc_pkg::REG_KBOT, 64'h0000_8000_7fff_0001);
    write_reg(rkc_pkg::REG_DIV, 64'd65535);
    for (int k = 0; k < 9; k++)
      send_pixel(8'hff, k[0] ? 8'hff : 8'h00, 8'h00);
    drain();
    write_reg(rkc_pkg::REG_DIV, 64'd1);
    for (int k = 0; k < 9; k++)
      send_pixel(8'hff, k[0] ? 8'hff : 8'h00, 8'h00);
    drain();

    // tall frame, then shrink the height while the frame is open
    write_reg(rkc_pkg::REG_WIDTH, 64'd4);
    write_reg(rkc_pkg::REG_HEIGHT, 64'd65535);
    repeat (8) send_random_pixel();
    drain();
    write_reg(rkc_pkg::REG_HEIGHT, 64'd2);
    repeat (4) send_random_pixel();
    drain();

    // binomial kernel under a long output hold-off
    write_reg(rkc_pkg::REG_KTOP, 64'h0000_0001_0002_0001);
    write_reg(rkc_pkg::REG_KMID, 64'h0000_0002_0004_0002);
    write_reg(rkc_pkg::REG_KBOT, 64'h0000_0001_0002_0001);
    write_reg(rkc_pkg::REG_DIV, 64'd16);
    write_reg(rkc_pkg::REG_WIDTH, 64'd6);
    write_reg(rkc_pkg::REG_HEIGHT, 64'd4);
    hold_req = 400;
    repeat (24) send_random_pixel();
    drain();

    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 63; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 63; end
        default: begin send_idle_pct = 22; recv_stall_pct = 22; end
      endcase
      for (int s = 0; s < 3; s++) begin
        random_setup();
        if (ph == 2 && s == 0) hold_req = 300;
        repeat (96) send_random_pixel();
        drain();
      end
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end
endmodule
